// ===== rtl/gtp_pkg.sv =====
// gtp_pkg: shared constants, register indexes and stage structs of the glyph blitter
// no dependencies; imported by every rtl module of the block

package gtp_pkg;

    localparam int GlyphSize = 8;
    localparam int PixCount  = GlyphSize * GlyphSize;
    localparam int PixIdxW   = $clog2(PixCount);
    localparam int RowIdxW   = $clog2(GlyphSize);

    // configuration register indexes
    localparam int CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] CfgTargetBase   = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgScreenWidth  = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgScreenHeight = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgLinePitch    = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgFourByte     = 3'd4;

    localparam logic [31:0] TransparentMask = 32'hFF00_0000;
    localparam logic [2:0]  Bytes32         = 3'd4;
    localparam logic [2:0]  Bytes24         = 3'd3;

    typedef struct packed {
        logic [31:0] target_base;
        logic [12:0] active_cols;
        logic [12:0] active_rows;
        logic [14:0] line_pitch;
        logic        four_byte;
    } t_cfg;

    // one draw request after clipping, ready for the scanner
    typedef struct packed {
        logic [31:0]         origin;
        logic [PixCount-1:0] mask;
        logic [PixCount-1:0] glyph;
        logic [31:0]         fg;
        logic [31:0]         bg;
        logic [2:0]          bpp;
    } t_job;

    // one pixel picked by the scanner
    typedef struct packed {
        logic [31:0]        origin;
        logic [RowIdxW-1:0] row;
        logic [RowIdxW-1:0] col;
        logic               fg_sel;
        logic [31:0]        fg;
        logic [31:0]        bg;
        logic [2:0]         bpp;
        logic               last;
    } t_pix;

endpackage

// ===== rtl/gtp_if.sv =====
// gtp_if: valid/ready channel interfaces for draw requests and pixel writes
// no dependencies

interface gtp_req_if;
    logic        valid;
    logic        ready;
    logic [11:0] x_pos;
    logic [11:0] y_pos;
    logic [63:0] glyph_bits;
    logic [31:0] fg_color;
    logic [31:0] bg_color;

    modport source(output valid, x_pos, y_pos, glyph_bits, fg_color, bg_color, input ready);
    modport sink(input valid, x_pos, y_pos, glyph_bits, fg_color, bg_color, output ready);
endinterface

interface gtp_wr_if;
    logic        valid;
    logic        ready;
    logic [31:0] write_address;
    logic [31:0] write_data;
    logic [2:0]  byte_count;
    logic        last_write;

    modport source(output valid, write_address, write_data, byte_count, last_write, input ready);
    modport sink(input valid, write_address, write_data, byte_count, last_write, output ready);
endinterface

// ===== rtl/gtp_prep.sv =====
// gtp_prep: three request stages - capture, clip/transparency mask and products, origin add
// depends on gtp_pkg and gtp_req_if

module gtp_prep (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gtp_pkg::t_cfg i_cfg,
    gtp_req_if.sink       i_req,
    output gtp_pkg::t_job o_job,
    output logic          o_job_valid,
    input  logic          i_job_ready
);
    import gtp_pkg::*;

    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    // stage 1 payload
    logic [11:0] r_x1, r_y1;
    logic [63:0] r_glyph1;
    logic [31:0] r_fg1, r_bg1;

    // stage 2 payload
    logic [26:0]         r_prod2, n_prod2;
    logic [13:0]         r_xoff2, n_xoff2;
    logic [PixCount-1:0] r_mask2, n_mask2;
    logic [63:0]         r_glyph2;
    logic [31:0]         r_fg2, r_bg2, n_fg2, n_bg2;
    logic [2:0]          r_bpp2, n_bpp2;

    t_job r_job3;

    logic [GlyphSize-1:0] row_ok, col_ok;
    logic                 opaque;

    assign en3 = !r_v3 || i_job_ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign i_req.ready = en1;

    always_comb begin
        opaque = (r_bg1 & TransparentMask) == 32'd0;
        for (int k = 0; k < GlyphSize; k++) begin
            row_ok[k] = ({1'b0, r_y1} + 13'(k)) < i_cfg.active_rows;
            col_ok[k] = ({1'b0, r_x1} + 13'(k)) < i_cfg.active_cols;
        end
        for (int i = 0; i < PixCount; i++) begin
            n_mask2[i] = row_ok[i / GlyphSize] & col_ok[i % GlyphSize]
                       & (r_glyph1[i] | opaque);
        end
        n_prod2 = 27'(r_y1) * 27'(i_cfg.line_pitch);
        if (i_cfg.four_byte) begin
            n_xoff2 = {r_x1, 2'b00};
            n_fg2   = r_fg1;
            n_bg2   = r_bg1;
            n_bpp2  = Bytes32;
        end else begin
            n_xoff2 = {1'b0, r_x1, 1'b0} + {2'b00, r_x1};
            n_fg2   = {8'h00, r_fg1[23:0]};
            n_bg2   = {8'h00, r_bg1[23:0]};
            n_bpp2  = Bytes24;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_req.valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_req.valid) begin
            r_x1     <= i_req.x_pos;
            r_y1     <= i_req.y_pos;
            r_glyph1 <= i_req.glyph_bits;
            r_fg1    <= i_req.fg_color;
            r_bg1    <= i_req.bg_color;
        end
        if (en2 && r_v1) begin
            r_prod2  <= n_prod2;
            r_xoff2  <= n_xoff2;
            r_mask2  <= n_mask2;
            r_glyph2 <= r_glyph1;
            r_fg2    <= n_fg2;
            r_bg2    <= n_bg2;
            r_bpp2   <= n_bpp2;
        end
        if (en3 && r_v2) begin
            r_job3.origin <= i_cfg.target_base + 32'(r_prod2) + 32'(r_xoff2);
            r_job3.mask   <= r_mask2;
            r_job3.glyph  <= r_glyph2;
            r_job3.fg     <= r_fg2;
            r_job3.bg     <= r_bg2;
            r_job3.bpp    <= r_bpp2;
        end
    end

    assign o_job       = r_job3;
    assign o_job_valid = r_v3;

endmodule

// ===== rtl/gtp_scan.sv =====
// gtp_scan: walks the draw mask of one request, lowest pixel first, one pixel per cycle unless the output stalls
// depends on gtp_pkg

module gtp_scan (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gtp_pkg::t_job i_job,
    input  logic          i_job_valid,
    output logic          o_job_ready,
    output gtp_pkg::t_pix o_pix,
    output logic          o_pix_valid,
    input  logic          i_pix_ready
);
    import gtp_pkg::*;

    logic                r_busy;
    logic [PixCount-1:0] r_mask;
    t_job                r_job;
    logic                r_pv;
    t_pix                r_pix;

    logic [PixIdxW-1:0]  sel;
    logic [PixCount-1:0] rest;
    logic                last, out_en, emit, free;

    always_comb begin
        sel = '0;
        for (int i = PixCount - 1; i >= 0; i--) begin
            if (r_mask[i]) sel = PixIdxW'(i);
        end
        rest = r_mask & (r_mask - PixCount'(1));
        last = rest == '0;
    end

    assign out_en      = !r_pv || i_pix_ready;
    assign emit        = r_busy && out_en;
    assign free        = !r_busy || (emit && last);
    assign o_job_ready = free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pv   <= 1'b0;
        end else begin
            if (i_job_valid && free) begin
                r_busy <= i_job.mask != '0;
            end else if (emit) begin
                r_busy <= !last;
            end
            if (out_en) r_pv <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job_valid && free) begin
            r_mask <= i_job.mask;
            r_job  <= i_job;
        end else if (emit) begin
            r_mask <= rest;
        end
        if (emit) begin
            r_pix.origin <= r_job.origin;
            r_pix.row    <= sel[PixIdxW-1 -: RowIdxW];
            r_pix.col    <= sel[RowIdxW-1:0];
            r_pix.fg_sel <= r_job.glyph[sel];
            r_pix.fg     <= r_job.fg;
            r_pix.bg     <= r_job.bg;
            r_pix.bpp    <= r_job.bpp;
            r_pix.last   <= last;
        end
    end

    assign o_pix       = r_pix;
    assign o_pix_valid = r_pv;

endmodule

// ===== rtl/gtp_emit.sv =====
// gtp_emit: pixel offsets and colour select, then final address add into the output register
// depends on gtp_pkg and gtp_wr_if

module gtp_emit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [14:0]   i_line_pitch,
    input  gtp_pkg::t_pix i_pix,
    input  logic          i_pix_valid,
    output logic          o_pix_ready,
    gtp_wr_if.source      o_wr
);
    import gtp_pkg::*;

    logic r_va, r_vb;
    logic en_a, en_b;

    logic [31:0] r_origin_a;
    logic [17:0] r_roff_a;
    logic [4:0]  r_coff_a;
    logic [31:0] r_data_a;
    logic [2:0]  r_bpp_a;
    logic        r_last_a;

    logic [31:0] r_addr_b, r_data_b;
    logic [2:0]  r_bpp_b;
    logic        r_last_b;

    assign en_b        = !r_vb || o_wr.ready;
    assign en_a        = !r_va || en_b;
    assign o_pix_ready = en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (en_a) r_va <= i_pix_valid;
            if (en_b) r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_pix_valid) begin
            r_origin_a <= i_pix.origin;
            r_roff_a   <= 18'(i_pix.row) * 18'(i_line_pitch);
            r_coff_a   <= 5'(i_pix.col) * 5'(i_pix.bpp);
            r_data_a   <= i_pix.fg_sel ? i_pix.fg : i_pix.bg;
            r_bpp_a    <= i_pix.bpp;
            r_last_a   <= i_pix.last;
        end
        if (en_b && r_va) begin
            r_addr_b <= r_origin_a + 32'(r_roff_a) + 32'(r_coff_a);
            r_data_b <= r_data_a;
            r_bpp_b  <= r_bpp_a;
            r_last_b <= r_last_a;
        end
    end

    assign o_wr.valid         = r_vb;
    assign o_wr.write_address = r_addr_b;
    assign o_wr.write_data    = r_data_b;
    assign o_wr.byte_count    = r_bpp_b;
    assign o_wr.last_write    = r_last_b;

endmodule

// ===== rtl/glyph_to_pixel_writes_top.sv =====
// glyph_to_pixel_writes_top: 8x8 glyph blitter, one draw request in, pixel writes out
// path: capture, clip, origin add, scanner output, offset and address registers
// throughput: one pixel write beat per cycle unless o_wr stalls; the scanner takes
//   the next request as it emits the last pixel of the current one
// reset: synchronous active low, clears all valid bits, config registers to zero
//   except the pixel format, which comes up as 32-bit
// depends on gtp_pkg, gtp_if, gtp_prep, gtp_scan, gtp_emit

module glyph_to_pixel_writes_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [gtp_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [31:0]                    i_cfg_data,
    gtp_req_if.sink                        i_req,
    gtp_wr_if.source                       o_wr
);
    import gtp_pkg::*;

    // configuration registers, to be written only while the block is drained; the block does not enforce this
    logic [31:0] r_target_base;
    logic [12:0] r_active_cols;
    logic [12:0] r_active_rows;
    logic [14:0] r_line_pitch;
    logic        r_four_byte;
    t_cfg        cfg;

    // request pipe to scanner
    t_job job;
    logic job_valid, job_ready;

    // scanner to address stages
    t_pix pix;
    logic pix_valid, pix_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_base <= '0;
            r_active_cols <= '0;
            r_active_rows <= '0;
            r_line_pitch  <= '0;
            r_four_byte   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CfgTargetBase:   r_target_base <= i_cfg_data;
                CfgScreenWidth:  r_active_cols <= i_cfg_data[12:0];
                CfgScreenHeight: r_active_rows <= i_cfg_data[12:0];
                CfgLinePitch:    r_line_pitch  <= i_cfg_data[14:0];
                CfgFourByte:     r_four_byte   <= i_cfg_data[0];
                default: ;  // unused indexes, write dropped
            endcase
        end
    end

    always_comb begin
        cfg.target_base = r_target_base;
        cfg.active_cols = r_active_cols;
        cfg.active_rows = r_active_rows;
        cfg.line_pitch  = r_line_pitch;
        cfg.four_byte   = r_four_byte;
    end

    // capture, clip mask and y*pitch, origin add
    gtp_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req       (i_req),
        .o_job       (job),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready)
    );

    // lowest-set-bit walk over the 64 pixel mask; empty requests drop here
    gtp_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .o_pix       (pix),
        .o_pix_valid (pix_valid),
        .i_pix_ready (pix_ready)
    );

    // row*pitch and col*bpp offsets, then address add into the output register
    gtp_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_line_pitch (r_line_pitch),
        .i_pix        (pix),
        .i_pix_valid  (pix_valid),
        .o_pix_ready  (pix_ready),
        .o_wr         (o_wr)
    );

    // byte count follows the pixel format register
    a_bytes_match_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.valid |-> (r_four_byte ? (o_wr.byte_count == Bytes32)
                                    : (o_wr.byte_count == Bytes24)))
        else $error("byte count does not match pixel format");

    // 24-bit writes never carry a top colour byte
    a_24bit_top_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr.valid && !r_four_byte) |-> (o_wr.write_data[31:24] == 8'h00))
        else $error("top data byte set in 24-bit mode");

    // nothing left on the output after reset
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_wr.valid)
        else $error("write beat valid right after reset");

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for glyph_to_pixel_writes_top, the 8x8 glyph blitter
// drives draw requests and register writes, predicts every pixel write, checks each beat
// depends on gtp_pkg, gtp_if and the rtl of glyph_to_pixel_writes_top
`timescale 1ns / 1ps

module tb_top;
    import gtp_pkg::*;

    // random part: several register settings, this many draw requests under each
    localparam int RandPhases = 6;
    localparam int PhaseReqs  = 80;
    // a request that draws nothing gives no beat to wait for
    localparam int IdleTail   = 20;
    // timeout covers the slowest legal run (64 writes per request, longest write stalls)
    localparam longint TimeoutNs = 64'd50_000_000;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [63:0] glyph;
        logic [31:0] fg;
        logic [31:0] bg;
    } draw_req_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] data;
        logic [2:0]  nbytes;
        logic        last;
    } pix_write_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_idx;
    logic [31:0]         cfg_data;

    gtp_req_if req_ch();
    gtp_wr_if  wr_ch();

    glyph_to_pixel_writes_top u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_wr       (wr_ch)
    );

    // testbench copy of the register file, updated as each register write goes out
    t_cfg        shadow_cfg;
    draw_req_t   draw_q[$];     // requests waiting for the driver
    pix_write_t  pixel_q[$];    // pixel writes predicted but not yet seen
    draw_req_t   in_flight;     // request currently offered on the request channel
    int unsigned req_gap;
    int unsigned wr_stall;
    bit          steady_req;    // no idle cycles on the request side
    bit          steady_wr;     // no stalls on the write side
    int unsigned mismatches;
    int unsigned beat_no;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #(TimeoutNs);
        $display("glyph_to_pixel_writes_top regression: fail");
        $finish;
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int unsigned pick_gap(input bit steady);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // expected pixel writes of one request under the current registers, row-major;
    // each write is held back one step so the final one can carry the last flag
    function automatic void predict_writes(input draw_req_t rq);
        logic [31:0] bpp;
        logic [31:0] data_mask;
        logic [31:0] x32;
        logic [31:0] y32;
        logic [31:0] line_addr;
        logic [31:0] colour;
        logic [7:0]  line_bits;
        bit          opaque;
        bit          drawn;
        bit          have_prev;
        pix_write_t  prev;
        bpp       = shadow_cfg.four_byte ? 32'(Bytes32) : 32'(Bytes24);
        data_mask = shadow_cfg.four_byte ? 32'hFFFF_FFFF : 32'h00FF_FFFF;
        opaque    = (rq.bg & TransparentMask) == 32'h0;
        x32       = 32'(rq.x);
        y32       = 32'(rq.y);
        have_prev = 1'b0;
        prev      = '0;
        for (int row = 0; row < GlyphSize; row++) begin
            // clipped rows and columns only grow with the index, so skipping equals stopping
            if (y32 + row < 32'(shadow_cfg.active_rows)) begin
                line_bits = rq.glyph[row*8 +: 8];
                line_addr = shadow_cfg.target_base + (y32 + row) * 32'(shadow_cfg.line_pitch)
                          + x32 * bpp;
                for (int col = 0; col < GlyphSize; col++) begin
                    if (x32 + col < 32'(shadow_cfg.active_cols)) begin
                        drawn  = 1'b1;
                        colour = rq.fg;
                        if (!line_bits[col]) begin
                            colour = rq.bg;
                            drawn  = opaque;
                        end
                        if (drawn) begin
                            if (have_prev)
                                pixel_q.push_back(prev);
                            prev.addr   = line_addr + col * bpp;
                            prev.data   = colour & data_mask;
                            prev.nbytes = shadow_cfg.four_byte ? Bytes32 : Bytes24;
                            prev.last   = 1'b0;
                            have_prev   = 1'b1;
                        end
                    end
                end
            end
        end
        if (have_prev) begin
            prev.last = 1'b1;
            pixel_q.push_back(prev);
        end
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] write beat %0d: %s expected %h got %h",
                     $time, beat_no, what, want_v, got_v);
    endtask

    // request driver: one beat per queued request, random idle cycles between beats
    always @(posedge clk) begin : driver
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
            req_gap      <= 0;
        end else begin
            // accepted beat: predict its writes under the registers in force now
            if (req_ch.valid && req_ch.ready)
                predict_writes(in_flight);
            if (!req_ch.valid || req_ch.ready) begin
                if (req_gap != 0) begin
                    req_ch.valid <= 1'b0;
                    req_gap      <= req_gap - 1;
                end else if (draw_q.size() != 0) begin
                    in_flight          = draw_q.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.x_pos      <= in_flight.x;
                    req_ch.y_pos      <= in_flight.y;
                    req_ch.glyph_bits <= in_flight.glyph;
                    req_ch.fg_color   <= in_flight.fg;
                    req_ch.bg_color   <= in_flight.bg;
                    req_gap           <= pick_gap(steady_req);
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // write monitor: random back-pressure, every accepted beat checked against the oldest
    // pending prediction
    always @(posedge clk) begin : monitor
        pix_write_t want;
        if (!rst_n) begin
            wr_ch.ready <= 1'b0;
            wr_stall    <= 0;
        end else begin
            if (wr_ch.valid && wr_ch.ready) begin
                if (pixel_q.size() == 0) begin
                    flag_mismatch("write with none pending, address", 32'h0,
                                  wr_ch.write_address);
                end else begin
                    want = pixel_q.pop_front();
                    if (wr_ch.write_address !== want.addr)
                        flag_mismatch("write_address", want.addr, wr_ch.write_address);
                    if (wr_ch.write_data !== want.data)
                        flag_mismatch("write_data", want.data, wr_ch.write_data);
                    if (wr_ch.byte_count !== want.nbytes)
                        flag_mismatch("byte_count", 32'(want.nbytes), 32'(wr_ch.byte_count));
                    if (wr_ch.last_write !== want.last)
                        flag_mismatch("last_write", 32'(want.last), 32'(wr_ch.last_write));
                end
                beat_no++;
            end
            if (wr_stall != 0) begin
                wr_ch.ready <= 1'b0;
                wr_stall    <= wr_stall - 1;
            end else begin
                wr_ch.ready <= 1'b1;
                wr_stall    <= pick_gap(steady_wr);
            end
        end
    end

    // one register write, sampled at the next rising edge; the caller lowers the enable
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        case (idx)
            CfgTargetBase:   shadow_cfg.target_base = value;
            CfgScreenWidth:  shadow_cfg.active_cols = value[12:0];
            CfgScreenHeight: shadow_cfg.active_rows = value[12:0];
            CfgLinePitch:    shadow_cfg.line_pitch  = value[14:0];
            CfgFourByte:     shadow_cfg.four_byte   = value[0];
            default: ;
        endcase
    endtask

    // full register set; with junk the unused high data bits are random and the
    // unmapped indexes get a write that must be ignored
    task automatic apply_config(input logic [31:0] base, input logic [12:0] width,
                                input logic [12:0] height, input logic [14:0] pitch,
                                input logic four, input bit junk);
        logic [31:0] noise;
        noise = junk ? $urandom : 32'h0;
        write_reg(CfgTargetBase, base);
        write_reg(CfgScreenWidth, {noise[31:13], width});
        write_reg(CfgScreenHeight, {noise[30:12], height});
        write_reg(CfgLinePitch, {noise[29:13], pitch});
        write_reg(CfgFourByte, {noise[31:1], four});
        if (junk) begin
            for (int k = int'(CfgFourByte) + 1; k < (1 << CfgIdxW); k++)
                write_reg(k[CfgIdxW-1:0], $urandom);
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait until the driver is empty and every predicted write has been seen, then let
    // a request that draws nothing clear the pipeline; checked on the falling edge so
    // that a beat just set up by the driver is already visible
    task automatic drain();
        @(negedge clk);
        while (draw_q.size() != 0 || req_ch.valid || pixel_q.size() != 0)
            @(negedge clk);
        repeat (IdleTail) @(posedge clk);
    endtask

    task automatic queue_req(input logic [11:0] x, input logic [11:0] y,
                             input logic [63:0] glyph, input logic [31:0] fg,
                             input logic [31:0] bg);
        draw_q.push_back('{x: x, y: y, glyph: glyph, fg: fg, bg: bg});
    endtask

    // screen dimension: mostly moderate, sometimes zero, tiny, the nominal top or the
    // register's full range
    function automatic logic [12:0] random_dim();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 13'd0;
            1:       return 13'd4096;
            2:       return 13'd8191;
            3, 4:    return 13'($urandom_range(1, 16));
            default: return 13'($urandom_range(17, 4096));
        endcase
    endfunction

    // random request, usually placed on or just past the visible area so that most
    // requests draw, now and then anywhere in the coordinate range
    function automatic draw_req_t random_req();
        draw_req_t   rq;
        int unsigned xmax;
        int unsigned ymax;
        xmax = (shadow_cfg.active_cols > 4088) ? 4095 : shadow_cfg.active_cols + 7;
        ymax = (shadow_cfg.active_rows > 4088) ? 4095 : shadow_cfg.active_rows + 7;
        if ($urandom_range(0, 3) == 0) begin
            rq.x = 12'($urandom_range(0, 4095));
            rq.y = 12'($urandom_range(0, 4095));
        end else begin
            rq.x = 12'($urandom_range(0, xmax));
            rq.y = 12'($urandom_range(0, ymax));
        end
        case ($urandom_range(0, 3))
            0:       rq.glyph = {$urandom, $urandom} & {$urandom, $urandom};
            1:       rq.glyph = 64'h1 << $urandom_range(0, 63);
            2:       rq.glyph = ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: rq.glyph = {$urandom, $urandom};
        endcase
        rq.fg = $urandom;
        // half the requests with an opaque background, half with any top byte
        rq.bg = ($urandom_range(0, 1) != 0) ? $urandom : ($urandom & ~TransparentMask);
        return rq;
    endfunction

    initial begin : stimulus
        logic [31:0] base;
        logic [14:0] pitch;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = CfgTargetBase;
        cfg_data          = 32'h0;
        req_ch.valid      = 1'b0;
        req_ch.x_pos      = '0;
        req_ch.y_pos      = '0;
        req_ch.glyph_bits = '0;
        req_ch.fg_color   = '0;
        req_ch.bg_color   = '0;
        wr_ch.ready       = 1'b0;
        shadow_cfg        = '{target_base: 32'h0, active_cols: 13'd0, active_rows: 13'd0,
                              line_pitch: 15'd0, four_byte: 1'b1};
        steady_req        = 1'b0;
        steady_wr         = 1'b0;
        mismatches        = 0;
        beat_no           = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // registers at reset: a zero-sized screen clips everything
        queue_req(12'd0, 12'd0, '1, 32'hFFFF_FFFF, 32'h0);
        queue_req(12'd3, 12'd5, 64'hA5A5_5A5A_0F0F_F0F0, 32'h1234_5678, 32'h0000_0001);
        drain();

        // ordinary 32-bit screen
        apply_config(32'h0010_0000, 13'd640, 13'd480, 15'd2560, 1'b1, 1'b0);
        queue_req(12'd0, 12'd0, '1, 32'hFFFF_FFFF, 32'h0);                    // all foreground
        queue_req(12'd8, 12'd0, '0, 32'h0, 32'h00FF_FFFF);                    // all background
        // lowest bit of the top byte already makes the background transparent
        queue_req(12'd16, 12'd8, 64'h55AA_55AA_55AA_55AA, 32'hDEAD_BEEF, 32'h0100_0000);
        queue_req(12'd24, 12'd8, '0, 32'hCAFE_F00D, 32'hFF00_0000);           // draws nothing
        queue_req(12'd636, 12'd100, 64'h0F1E_2D3C_4B5A_6978, 32'h00C0_FFEE, 32'h0);
        queue_req(12'd100, 12'd476, 64'h8142_2418_1824_4281, 32'h0000_00FF, 32'h0000_FF00);
        queue_req(12'd639, 12'd479, '1, 32'h7777_7777, 32'h0);               // corner pixel
        queue_req(12'd640, 12'd0, '1, 32'h1111_1111, 32'h0);                 // right of screen
        queue_req(12'd4095, 12'd4095, '1, 32'h2222_2222, 32'h0);
        // first and last pixel of the cell only
        queue_req(12'd32, 12'd32, 64'h8000_0000_0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // 24-bit pixels, base near the top of the address space so addresses wrap
        apply_config(32'hFFFF_FF00, 13'd4096, 13'd4096, 15'd16384, 1'b0, 1'b0);
        queue_req(12'd4095, 12'd4095, '1, 32'hFFFF_FFFF, 32'h0);
        queue_req(12'd4088, 12'd4088, 64'h0123_4567_89AB_CDEF, 32'hFF80_4020, 32'h00AB_CDEF);
        queue_req(12'd0, 12'd0, 64'h1, 32'h89AB_CDEF, 32'h8000_0000);
        drain();

        // every register at its full range, high data bits set to junk
        apply_config(32'hFFFF_FFFF, 13'd8191, 13'd8191, 15'd32767, 1'b1, 1'b1);
        queue_req(12'd4095, 12'd4095, '1, 32'hFFFF_FFFF, 32'h0);
        queue_req(12'd0, 12'd0, '0, 32'h0, 32'h0);
        queue_req(12'd2048, 12'd1024, 64'hFEDC_BA98_7654_3210, 32'h5A5A_A5A5, 32'h00F0_0F00);
        drain();

        // random settings; each phase ends by draining, so the sender also pauses
        // until every predicted write has come
        for (int ph = 0; ph < RandPhases; ph++) begin
            case ($urandom_range(0, 3))
                0:       base = 32'h0;
                1:       base = 32'hFFFF_FFFF;
                default: base = $urandom;
            endcase
            case ($urandom_range(0, 4))
                0:       pitch = 15'd0;
                1:       pitch = 15'd16384;
                2:       pitch = 15'd32767;
                default: pitch = 15'($urandom_range(1, 16384));
            endcase
            apply_config(base, random_dim(), random_dim(), pitch, 1'($urandom_range(0, 1)),
                         $urandom_range(0, 1) != 0);
            // some phases run back to back on one side or both
            steady_req = $urandom_range(0, 3) == 0;
            steady_wr  = $urandom_range(0, 3) == 0;
            for (int n = 0; n < PhaseReqs; n++)
                draw_q.push_back(random_req());
            drain();
        end

        if (mismatches == 0)
            $display("glyph_to_pixel_writes_top regression: pass");
        else
            $display("glyph_to_pixel_writes_top regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/gtp_pkg.sv
rtl/gtp_if.sv
rtl/gtp_prep.sv
rtl/gtp_scan.sv
rtl/gtp_emit.sv
rtl/glyph_to_pixel_writes_top.sv
tb/tb_top.sv
